/* hw/rtl/torl_pkg.sv */
package torl_pkg;

	localparam int unsigned LAST_SLOT_DEF = 32;
	localparam int unsigned ID_W          = 16;
	localparam int unsigned STAMP_W       = 32;
	localparam int unsigned SLOT_IDX_W    = 6;
	localparam int unsigned OFFSET_W      = 16;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd300;

	localparam int unsigned S_TDATA_W = 56;
	localparam int unsigned M_TDATA_W = 56;

	typedef enum logic [1:0] {
		OP_ADD_IN  = 2'd0,
		OP_ADD_OUT = 2'd1,
		OP_READ    = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef struct packed {
		logic               occ;
		logic [ID_W-1:0]    contact;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// ripple between neighbouring cells
	typedef struct packed {
		logic   all_skip;  // every earlier slot is newer than the new stamp
		logic   abort;     // id already sits in a newer slot
		logic   shift;     // this slot takes the previous slot's old entry
		logic   present;   // id seen in an earlier slot
		entry_t carry;     // previous slot's old entry
	} chain_t;

	typedef struct packed {
		logic               is_add;
		logic [ID_W-1:0]    contact;
		logic [STAMP_W-1:0] stamp;
	} cell_req_t;

endpackage

/* hw/rtl/torl_cell.sv */
module torl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  torl_pkg::cell_req_t req,
	input  logic               commit,
	input  logic               abort_all,
	input  torl_pkg::chain_t   chain_in,
	output torl_pkg::chain_t   chain_out,
	output torl_pkg::entry_t   entry
);
	import torl_pkg::*;

	entry_t entry_q;
	logic   skip;
	logic   match;
	logic   ins_here;

	assign skip     = entry_q.occ && (entry_q.stamp > req.stamp);
	assign match    = entry_q.occ && (entry_q.contact == req.contact);
	assign ins_here = chain_in.all_skip && !skip;

	always_comb begin
		chain_out.all_skip = chain_in.all_skip && skip;
		chain_out.abort    = chain_in.abort || (chain_in.all_skip && skip && match);
		// shift runs on until an empty slot or the old copy of the id
		chain_out.shift    = (ins_here || chain_in.shift) && entry_q.occ && !match;
		chain_out.present  = chain_in.present || match;
		chain_out.carry    = entry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (commit && req.is_add && !abort_all) begin
			if (ins_here) begin
				entry_q.occ     <= 1'b1;
				entry_q.contact <= req.contact;
				entry_q.stamp   <= req.stamp;
			end else if (chain_in.shift) begin
				entry_q <= chain_in.carry;
			end
		end
	end

	assign entry = entry_q;

endmodule

/* hw/rtl/timestamp_ordered_recent_list_core.sv */
// Recency list of contact ids, newest first, held in a row of slot cells.
// Input channel s_*: one request per transfer, kind in s_tuser (add incoming,
// add outgoing, read slot, presence query). Output channel m_*: exactly one
// result per request, in request order; adds return all zeros.
// cfg_we/cfg_wdata set the offset taken off now_seconds for incoming adds
// (saturating at zero); write it only while no request is in flight.
// A request taken is held in the request register and its result is on m_*
// once the output register has taken it. Throughput is one request per
// cycle while the output is not stalled: the adjusted stamp is formed on
// entry, then the insert, shift, search and slot read settle
// combinationally along the cell row; the output register holds the result.
// If m_tready is low the result is held; one further request can be taken
// and waits in the request register, after which s_tready drops.
// Reset empties every slot, clears both channels and loads the offset
// with 300.
module timestamp_ordered_recent_list_core #(
	parameter int unsigned LAST_SLOT = torl_pkg::LAST_SLOT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// contact_id[15:0], now_seconds[47:16], slot_index[53:48], zero pad
	input  logic [torl_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// entry_contact[15:0], entry_stamp[47:16], is_present[48], zero pad
	output logic [torl_pkg::M_TDATA_W-1:0]  m_tdata,
	// entry_valid[0]
	output logic [0:0]                      m_tuser,
	input  logic                            cfg_we,
	input  logic [torl_pkg::OFFSET_W-1:0]   cfg_wdata
);
	import torl_pkg::*;

	localparam int unsigned NUM_SLOTS = LAST_SLOT + 1;
	localparam int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(LAST_SLOT);

	logic [OFFSET_W-1:0]   offset_q;
	logic                  busy_q;
	opcode_t               op_q;
	logic [ID_W-1:0]       id_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic [SLOT_IDX_W-1:0] idx_q;

	logic                  out_valid_q;
	logic                  out_entry_valid_q;
	logic [ID_W-1:0]       out_contact_q;
	logic [STAMP_W-1:0]    out_stamp_q;
	logic                  out_present_q;

	logic                  accept;
	logic                  exec;
	opcode_t               in_op;
	logic [STAMP_W-1:0]    in_now;
	logic [STAMP_W-1:0]    in_off;
	logic [STAMP_W-1:0]    adj_stamp;

	cell_req_t             req;
	chain_t                chain [NUM_SLOTS+1];
	entry_t                entries [NUM_SLOTS];

	entry_t                rd_entry;
	logic                  res_entry_valid;
	logic [ID_W-1:0]       res_contact;
	logic [STAMP_W-1:0]    res_stamp;
	logic                  res_present;

	assign exec     = busy_q && (!out_valid_q || m_tready);
	assign s_tready = !busy_q || exec;
	assign accept   = s_tvalid && s_tready;

	assign in_op  = opcode_t'(s_tuser);
	assign in_now = s_tdata[47:16];
	assign in_off = STAMP_W'(offset_q);

	always_comb begin
		adj_stamp = in_now;
		if (in_op == OP_ADD_IN) begin
			adj_stamp = (in_now >= in_off) ? (in_now - in_off) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_op;
			id_q    <= s_tdata[15:0];
			stamp_q <= adj_stamp;
			idx_q   <= s_tdata[53:48];
		end
	end

	assign req.is_add  = (op_q == OP_ADD_IN) || (op_q == OP_ADD_OUT);
	assign req.contact = id_q;
	assign req.stamp   = stamp_q;

	assign chain[0].all_skip = 1'b1;
	assign chain[0].abort    = 1'b0;
	assign chain[0].shift    = 1'b0;
	assign chain[0].present  = 1'b0;
	assign chain[0].carry    = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		torl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req       (req),
			.commit    (exec),
			.abort_all (chain[NUM_SLOTS].abort),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.entry     (entries[i])
		);
	end

	always_comb begin
		rd_entry = '0;
		if (idx_q <= LAST_IDX) begin
			rd_entry = entries[idx_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		res_entry_valid = 1'b0;
		res_contact     = '0;
		res_stamp       = '0;
		res_present     = 1'b0;
		unique case (op_q)
			OP_ADD_IN, OP_ADD_OUT: begin
			end
			OP_READ: begin
				if (rd_entry.occ) begin
					res_entry_valid = 1'b1;
					res_contact     = rd_entry.contact;
					res_stamp       = rd_entry.stamp;
				end
			end
			OP_QUERY: begin
				res_present = chain[NUM_SLOTS].present;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_entry_valid_q <= res_entry_valid;
			out_contact_q     <= res_contact;
			out_stamp_q       <= res_stamp;
			out_present_q     <= res_present;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_present_q, out_stamp_q, out_contact_q};
	assign m_tuser  = out_entry_valid_q;

endmodule

/* hw/rtl/torl_chk.sv */
module torl_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [torl_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [0:0]                      m_tuser
);
	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// a missing entry reads as all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[47:0] == 48'd0)
		else $error("invalid entry carries data");

	// a slot read never reports presence
	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[48])
		else $error("entry_valid and is_present both set");

endmodule

bind timestamp_ordered_recent_list_core torl_chk u_torl_chk (.*);
